@@ hw/rtl/cs_pkg.sv @@
// Shared constants and types of the chunk sorter.
package cs_pkg;

  // Largest chunk the store can hold
  localparam int unsigned MAX_CHUNK = 64;
  // Index into the chunk store
  localparam int unsigned IDX_W     = $clog2(MAX_CHUNK);
  // Fill count, able to hold MAX_CHUNK itself
  localparam int unsigned CNT_W     = $clog2(MAX_CHUNK + 1);
  // Width of the run length register
  localparam int unsigned SIZE_W    = 7;
  // Width of one stored value
  localparam int unsigned DATA_W    = 32;

  // Register index of the run length
  localparam logic REG_RUN_LEN      = 1'b0;
  // Reset value of the run length
  localparam logic [SIZE_W-1:0] RUN_LEN_RST = SIZE_W'(64);

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DRAIN
  } state_e;

endpackage

@@ hw/rtl/cs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/chunk_sorter.sv @@
// Top level of the chunk sorter: insertion sequencer, drain and register port.
// Insertion: a value arriving at the fill position moves down slot by slot,
//   alternating READ and CMP states; one compare per RAM read.
// A closing chunk then drains: first result the cycle after the drain starts,
//   one result per cycle; busy drops as the last result is presented.
// Reset clears the sequencer, fill count and run length (to 64); the chunk
//   store is not cleared. Results cannot be stalled by the receiver.
module chunk_sorter
  import cs_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Command channel
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     end_of_data_i,
  // Result channel
  output logic                     result_valid_o,
  output logic signed [DATA_W-1:0] sorted_value_o,
  output logic                     last_of_run_o,
  // Register port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         fill_q, fill_d;
  logic [IDX_W-1:0]         pos_q, pos_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic signed [DATA_W-1:0] key_q, key_d;
  logic                     eod_q, eod_d;
  logic [SIZE_W-1:0]        run_len_q;
  logic                     res_valid_q, res_valid_d;
  logic                     last_q, last_d;

  logic                     accept;
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr, ram_raddr;
  logic signed [DATA_W-1:0] ram_wdata, ram_rdata;
  logic [SIZE_W-1:0]        eff_size;
  logic [CNT_W-1:0]         fill_inc;
  logic                     close_chunk;
  logic                     key_less;
  logic                     drain_last;
  logic                     cfg_write;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // Saturate the run length into 1..MAX_CHUNK
  always_comb begin
    if (run_len_q == '0) begin
      eff_size = SIZE_W'(1);
    end else if (run_len_q > SIZE_W'(MAX_CHUNK)) begin
      eff_size = SIZE_W'(MAX_CHUNK);
    end else begin
      eff_size = run_len_q;
    end
  end

  assign fill_inc    = fill_q + CNT_W'(1);
  assign close_chunk = eod_q || (SIZE_W'(fill_inc) >= eff_size);
  assign key_less    = key_q < ram_rdata;
  assign drain_last  = (idx_q == IDX_W'(fill_q - CNT_W'(1)));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_READ;
      end
      ST_READ: begin
        if (pos_q != '0) begin
          state_d = ST_CMP;
        end else begin
          state_d = close_chunk ? ST_DRAIN : ST_IDLE;
        end
      end
      ST_CMP: begin
        if (key_less) begin
          state_d = ST_READ;
        end else begin
          state_d = close_chunk ? ST_DRAIN : ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (drain_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    fill_d      = fill_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    key_d       = key_q;
    eod_d       = eod_q;
    res_valid_d = 1'b0;
    last_d      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = pos_q;
    ram_wdata   = key_q;
    ram_raddr   = pos_q - IDX_W'(1);
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_d = value_i;
          eod_d = end_of_data_i;
          pos_d = IDX_W'(fill_q);
        end
      end
      ST_READ: begin
        // Land at slot zero, else fetch the neighbor below
        if (pos_q == '0) begin
          ram_we = 1'b1;
          fill_d = fill_inc;
          idx_d  = '0;
        end
      end
      ST_CMP: begin
        if (key_less) begin
          // Shift the larger neighbor up one slot
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          pos_d     = pos_q - IDX_W'(1);
        end else begin
          // Place the key above the smaller or equal neighbor
          ram_we = 1'b1;
          fill_d = fill_inc;
          idx_d  = '0;
        end
      end
      ST_DRAIN: begin
        ram_raddr   = idx_q;
        res_valid_d = 1'b1;
        last_d      = drain_last;
        idx_d       = idx_q + IDX_W'(1);
        if (drain_last) fill_d = '0;
      end
      default: ;
    endcase
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    idx_q  <= idx_d;
    key_q  <= key_d;
    eod_q  <= eod_d;
    last_q <= last_d;
  end

  // Chunk store
  cs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_CHUNK)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign result_valid_o = res_valid_q;
  assign sorted_value_o = ram_rdata;
  assign last_of_run_o  = last_q;

  // Register port: write on the access phase of a transfer
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_RUN_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_len_q <= RUN_LEN_RST;
    end else if (cfg_write) begin
      run_len_q <= pwdata[SIZE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_RUN_LEN) ? 32'(run_len_q) : '0;

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(MAX_CHUNK))
    else $error("fill count above chunk capacity");

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (fill_q != '0))
    else $error("drain of an empty chunk");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !last_q) |-> (state_q == ST_DRAIN))
    else $error("run ended without last marker");

  a_run_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && last_q) |=> !res_valid_q)
    else $error("result right after end of run");

endmodule
